FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: hw/rtl/tps_pkg.sv
package tps_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned QDEPTH  = 4;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   val;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   clr;
    logic   ins;
    logic   fetch;
    entry_t peak;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   val;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_INS_RD,
    BK_INS_CMP,
    BK_INS_WR
  } back_state_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FETCH = 1'b1
  } action_e;

endpackage

FILE: hw/rtl/tps_ram.sv
module tps_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tps_fifo.sv
module tps_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tps_pkg::cmd_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output tps_pkg::cmd_t data_o,
  input  logic          pop_i
);

  localparam int unsigned AW = $clog2(tps_pkg::QDEPTH);

  tps_pkg::cmd_t mem_q [tps_pkg::QDEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign ready_o = count_q != (AW+1)'(tps_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + AW'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + AW'(1) : rptr_q;
    count_d = count_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/tps_front.sv
module tps_front #(
  parameter int unsigned TILE       = 50,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       action_i,
  input  logic [tps_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       frame_start_i,
  input  logic [tps_pkg::DIM_W-1:0]  width_i,
  input  logic [tps_pkg::DIM_W-1:0]  height_i,
  output logic                       cmd_valid_o,
  output tps_pkg::cmd_t              cmd_o,
  input  logic                       cmd_ready_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned MW = $clog2(TILE);
  localparam int unsigned TA = (MAX_WIDTH + TILE - 1) / TILE;
  localparam int unsigned TW = (TA > 1) ? $clog2(TA) : 1;
  localparam int unsigned DW = tps_pkg::DIM_W;

  logic [CW-1:0] col_q, col_d, col_e;
  logic [RW-1:0] row_q, row_d, row_e;
  logic [MW-1:0] tcol_q, tcol_d, tcol_e;
  logic [MW-1:0] rmod_q, rmod_d, rmod_e;
  logic [TW-1:0] tidx_q, tidx_d, tidx_e;
  logic          done_q, done_d;

  logic [tps_pkg::PIX_W-1:0]   best_val_q [TA];
  logic [tps_pkg::PIX_W-1:0]   best_val_d [TA];
  logic [tps_pkg::COORD_W-1:0] best_col_q [TA];
  logic [tps_pkg::COORD_W-1:0] best_row_q [TA];

  logic [DW-1:0]             wc, hc;
  logic                      take, start, active, row_end, last_row, tile_end, upd;
  logic [tps_pkg::PIX_W-1:0] bv;
  tps_pkg::entry_t           peak;

  assign ready_o = cmd_ready_i;
  assign take    = valid_i && ready_o && (action_i == tps_pkg::ACT_PIXEL);
  assign start   = take && frame_start_i;

  always_comb begin
    wc = (width_i == '0) ? DW'(1) : ((width_i > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : width_i);
    hc = (height_i == '0) ? DW'(1) :
         ((height_i > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : height_i);
  end

  always_comb begin
    col_e    = start ? '0 : col_q;
    row_e    = start ? '0 : row_q;
    tcol_e   = start ? '0 : tcol_q;
    rmod_e   = start ? '0 : rmod_q;
    tidx_e   = start ? '0 : tidx_q;
    active   = take && (start || !done_q);
    row_end  = DW'(col_e) >= wc - DW'(1);
    last_row = DW'(row_e) >= hc - DW'(1);
    tile_end = (tcol_e == MW'(TILE - 1) || row_end) && (rmod_e == MW'(TILE - 1) || last_row);
    bv       = start ? '0 : best_val_q[tidx_e];
    upd      = pixel_i > bv;
    peak.val = upd ? pixel_i : bv;
    peak.col = upd ? tps_pkg::COORD_W'(col_e) : best_col_q[tidx_e];
    peak.row = upd ? tps_pkg::COORD_W'(row_e) : best_row_q[tidx_e];
  end

  always_comb begin
    col_d  = col_e;
    row_d  = row_e;
    tcol_d = tcol_e;
    rmod_d = rmod_e;
    tidx_d = tidx_e;
    done_d = start ? 1'b0 : done_q;
    if (!active) begin
      col_d  = col_q;
      row_d  = row_q;
      tcol_d = tcol_q;
      rmod_d = rmod_q;
      tidx_d = tidx_q;
    end else if (row_end) begin
      col_d  = '0;
      tcol_d = '0;
      tidx_d = '0;
      if (last_row) begin
        done_d = 1'b1;
      end else begin
        row_d  = row_e + RW'(1);
        rmod_d = (rmod_e == MW'(TILE - 1)) ? '0 : rmod_e + MW'(1);
      end
    end else begin
      col_d = col_e + CW'(1);
      if (tcol_e == MW'(TILE - 1)) begin
        tcol_d = '0;
        tidx_d = tidx_e + TW'(1);
      end else begin
        tcol_d = tcol_e + MW'(1);
      end
    end
  end

  always_comb begin
    best_val_d = best_val_q;
    if (start) begin
      for (int i = 0; i < TA; i++) begin
        best_val_d[i] = '0;
      end
    end
    if (active) begin
      if (tile_end) begin
        best_val_d[tidx_e] = '0;
      end else if (upd) begin
        best_val_d[tidx_e] = pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      tcol_q <= '0;
      rmod_q <= '0;
      tidx_q <= '0;
      done_q <= 1'b1;
      for (int i = 0; i < TA; i++) begin
        best_val_q[i] <= '0;
      end
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      tcol_q     <= tcol_d;
      rmod_q     <= rmod_d;
      tidx_q     <= tidx_d;
      done_q     <= done_d;
      best_val_q <= best_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active && upd) begin
      best_col_q[tidx_e] <= tps_pkg::COORD_W'(col_e);
      best_row_q[tidx_e] <= tps_pkg::COORD_W'(row_e);
    end
  end

  always_comb begin
    cmd_o.clr   = start;
    cmd_o.ins   = active && tile_end && (peak.val != '0);
    cmd_o.fetch = valid_i && (action_i == tps_pkg::ACT_FETCH);
    cmd_o.peak  = peak;
    cmd_valid_o = valid_i && ready_o && (cmd_o.clr || cmd_o.ins || cmd_o.fetch);
  end

endmodule

FILE: hw/rtl/tps_back.sv
`include "assert_macros.svh"

module tps_back #(
  parameter int unsigned MAX_PEAKS = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tps_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  output tps_pkg::result_t out_o,
  input  logic             out_ready_i
);

  localparam int unsigned PW = $clog2(MAX_PEAKS);
  localparam logic [PW:0] MAXP = (PW+1)'(MAX_PEAKS);

  tps_pkg::back_state_e state_q, state_d;
  logic [PW-1:0]    head_q, head_d;
  logic [PW:0]      count_q, count_d;
  logic [PW:0]      idx_q, idx_d;
  logic [PW:0]      dest_q, dest_d;
  tps_pkg::entry_t  new_q, new_d;
  tps_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic                     we;
  logic [PW-1:0]            waddr, raddr;
  logic [tps_pkg::ENTRY_W-1:0] wdata, rdata;
  tps_pkg::entry_t          rd;
  logic [PW:0]              count_e, count_inc;
  logic [PW-1:0]            head_e;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, h} + k;
    if (s >= MAXP) begin
      s = s - MAXP;
    end
    return s[PW-1:0];
  endfunction

  assign rd        = tps_pkg::entry_t'(rdata);
  assign count_e   = cmd_i.clr ? '0 : count_q;
  assign head_e    = cmd_i.clr ? '0 : head_q;
  assign count_inc = (count_q == MAXP) ? MAXP : count_q + (PW+1)'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tps_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.fetch) begin
            if (!out_valid_q && count_q != '0) begin
              state_d = tps_pkg::BK_FETCH;
            end
          end else if (cmd_i.ins && count_e != '0) begin
            state_d = tps_pkg::BK_INS_RD;
          end
        end
      end
      tps_pkg::BK_FETCH:  state_d = tps_pkg::BK_IDLE;
      tps_pkg::BK_INS_RD: state_d = tps_pkg::BK_INS_CMP;
      tps_pkg::BK_INS_CMP: begin
        if (new_q.val > rd.val) begin
          state_d = (idx_q == '0) ? tps_pkg::BK_INS_WR : tps_pkg::BK_INS_RD;
        end else begin
          state_d = tps_pkg::BK_IDLE;
        end
      end
      tps_pkg::BK_INS_WR: state_d = tps_pkg::BK_IDLE;
      default:            state_d = tps_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    dest_d      = dest_q;
    new_d       = new_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = phys(head_q, dest_q);
    wdata       = new_q;
    raddr       = phys(head_q, idx_q);
    case (state_q)
      tps_pkg::BK_IDLE: begin
        raddr = head_q;
        if (cmd_valid_i) begin
          if (cmd_i.fetch) begin
            if (!out_valid_q) begin
              cmd_pop_o = 1'b1;
              if (count_q == '0) begin
                out_d       = '0;
                out_valid_d = 1'b1;
              end
            end
          end else begin
            cmd_pop_o = 1'b1;
            head_d    = head_e;
            count_d   = count_e;
            new_d     = cmd_i.peak;
            if (cmd_i.ins) begin
              if (count_e == '0) begin
                we      = 1'b1;
                waddr   = head_e;
                wdata   = cmd_i.peak;
                count_d = (PW+1)'(1);
              end else begin
                idx_d  = count_e - (PW+1)'(1);
                dest_d = count_e;
              end
            end
          end
        end
      end
      tps_pkg::BK_FETCH: begin
        out_d.valid = 1'b1;
        out_d.x     = rd.col;
        out_d.y     = rd.row;
        out_d.val   = rd.val;
        out_d.last  = count_q == (PW+1)'(1);
        out_valid_d = 1'b1;
        head_d      = phys(head_q, (PW+1)'(1));
        count_d     = count_q - (PW+1)'(1);
      end
      tps_pkg::BK_INS_CMP: begin
        if (new_q.val > rd.val) begin
          we     = dest_q != MAXP;
          wdata  = rd;
          idx_d  = (idx_q == '0) ? '0 : idx_q - (PW+1)'(1);
          dest_d = dest_q - (PW+1)'(1);
        end else if (dest_q != MAXP) begin
          we      = 1'b1;
          count_d = count_inc;
        end
      end
      tps_pkg::BK_INS_WR: begin
        we      = 1'b1;
        count_d = count_inc;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tps_pkg::BK_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    dest_q <= dest_d;
    new_q  <= new_d;
    out_q  <= out_d;
  end

  tps_ram #(
    .WIDTH(tps_pkg::ENTRY_W),
    .DEPTH(MAX_PEAKS)
  ) u_list (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= MAXP)
  `ASSERT_RST(a_pop_idle, clk_i, rst_ni, cmd_pop_o |-> state_q == tps_pkg::BK_IDLE)
  `ASSERT_RST(a_last_empty, clk_i, rst_ni, ($rose(out_valid_q) && out_q.last) |-> count_q == '0)
  `ASSERT_RST(a_fetch_load, clk_i, rst_ni, state_q == tps_pkg::BK_FETCH |=> out_valid_q)

endmodule

FILE: hw/rtl/tile_peak_sorter.sv
// Tile peak sorter: pixels arrive in raster order on the slave stream (tuser bit 0 selects
// fetch over pixel, tuser bit 1 marks the first pixel of a frame). Each TILE x TILE tile,
// edge tiles included, yields its brightest nonzero pixel into a list sorted by descending
// value; each fetch word returns the list head on the master stream, with tuser set when a
// peak was popped and tlast on the final entry. The front end takes one word per cycle
// while its 4-deep command queue has room. Behind the queue, a fetch on an empty list
// returns an all-zero word from idle, else it reads the list head and loads it in
// BK_FETCH, and waits while an earlier result word is still held; an insertion reads and
// compares each entry it moves past, split by the registered read of the list memory.
module tile_peak_sorter #(
  parameter int unsigned TILE       = 50,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_PEAKS  = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [1:0]  s_axis_tuser,   // [0] action, [1] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] peak_x, [19:10] peak_y, [27:20] peak_value
  output logic        m_axis_tuser,   // peak_valid
  output logic        m_axis_tlast,   // peak_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  logic [tps_pkg::DIM_W-1:0] width_q, height_q;
  logic                      fr_valid, q_ready, q_valid, q_pop;
  tps_pkg::cmd_t             fr_cmd, q_cmd;
  tps_pkg::result_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tps_pkg::DIM_W'(640);
      height_q <= tps_pkg::DIM_W'(480);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tps_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  tps_front #(
    .TILE      (TILE),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .action_i     (s_axis_tuser[0]),
    .pixel_i      (s_axis_tdata),
    .frame_start_i(s_axis_tuser[1]),
    .width_i      (width_q),
    .height_i     (height_q),
    .cmd_valid_o  (fr_valid),
    .cmd_o        (fr_cmd),
    .cmd_ready_i  (q_ready)
  );

  tps_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .data_i (fr_cmd),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_cmd),
    .pop_i  (q_pop)
  );

  tps_back #(
    .MAX_PEAKS(MAX_PEAKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_o      (res),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, res.val, res.y, res.x};
  assign m_axis_tuser = res.valid;
  assign m_axis_tlast = res.last;

endmodule
